/* rtl/mwpo_pkg.sv */
package mwpo_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int STEP_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAW_FALLING = 2'd2;

   localparam logic [1:0] WAVE_SINE     = 2'd0;
   localparam logic [1:0] WAVE_SAW      = 2'd1;
   localparam logic [1:0] WAVE_SQUARE   = 2'd2;
   localparam logic [1:0] WAVE_TRIANGLE = 2'd3;

   // Nyquist clamp: half a turn in 2^-32 units
   localparam logic [STEP_BITS-1:0] STEP_MAX = 32'h8000_0000;

   // Q30 coefficients of sin(pi/2 * x), odd terms through x^9
   localparam logic [63:0] SIN_C1 = 64'd1686629713;
   localparam logic [63:0] SIN_C3 = 64'd693598676;
   localparam logic [63:0] SIN_C5 = 64'd85569306;
   localparam logic [63:0] SIN_C7 = 64'd5026994;
   localparam logic [63:0] SIN_C9 = 64'd172272;

   typedef struct packed {
      logic [1:0]           wave_mode;
      logic [STEP_BITS-1:0] phase_step;
      logic                 saw_falling;
   } cfg_type;

endpackage

/* rtl/mwpo_if.sv */
interface mwpo_req_if;
   logic valid;
   logic ready;
   logic frame_last;

   modport source (output valid, output frame_last, input ready);
   modport sink (input valid, input frame_last, output ready);
endinterface

interface mwpo_rsp_if #(
   parameter int OUT_BITS = 16
);
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] sample_out;
   logic                       sample_last;

   modport source (output valid, output sample_out, output sample_last, input ready);
   modport sink (input valid, input sample_out, input sample_last, output ready);
endinterface

/* rtl/mwpo_csr.sv */
module mwpo_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mwpo_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mwpo_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output mwpo_pkg::cfg_type                    cfg
);

   mwpo_pkg::cfg_type cfg_ff;
   mwpo_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mwpo_pkg::CSR_WAVE_MODE:   cfg_in.wave_mode   = csr_wdata[1:0];
            mwpo_pkg::CSR_PHASE_STEP:  cfg_in.phase_step  = csr_wdata[mwpo_pkg::STEP_BITS-1:0];
            mwpo_pkg::CSR_SAW_FALLING: cfg_in.saw_falling = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/mwpo_phase.sv */
module mwpo_phase #(
   parameter int PHASE_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [mwpo_pkg::STEP_BITS-1:0]      phase_step,
   output logic [PHASE_BITS-1:0]               phase
);

   localparam int EXT_BITS = mwpo_pkg::STEP_BITS + PHASE_BITS;

   logic [mwpo_pkg::STEP_BITS-1:0] step_clamped;
   logic [EXT_BITS-1:0]            step_ext;
   logic [PHASE_BITS-1:0]          step_scaled;
   logic [PHASE_BITS-1:0]          phase_ff;
   logic [PHASE_BITS-1:0]          phase_in;

   assign step_clamped = (phase_step > mwpo_pkg::STEP_MAX) ? mwpo_pkg::STEP_MAX : phase_step;
   // rescale 2^-32 turn units to the accumulator width
   assign step_ext     = {step_clamped, {PHASE_BITS{1'b0}}};
   assign step_scaled  = step_ext[EXT_BITS-1 -: PHASE_BITS];

   assign phase_in = advance ? (phase_ff + step_scaled) : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign phase = phase_ff;

endmodule

/* rtl/mwpo_shaper.sv */
module mwpo_shaper #(
   parameter int PHASE_BITS     = 32,
   parameter int OUT_BITS       = 16,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic [PHASE_BITS-1:0]      phase,
   input  mwpo_pkg::cfg_type          cfg,
   output logic signed [OUT_BITS-1:0] sample
);

   localparam int EXT_BITS = PHASE_BITS + OUT_BITS + 1;
   localparam int QBITS    = SINE_ADDR_BITS - 2;
   localparam int QMAX     = 1 << QBITS;
   localparam int OSH      = 31 - OUT_BITS;

   localparam logic [OUT_BITS-1:0] FULL_SCALE = OUT_BITS'(1) << (OUT_BITS - 1);
   localparam logic [OUT_BITS-1:0] MAX_POS    = FULL_SCALE - OUT_BITS'(1);
   localparam logic [OUT_BITS:0]   TWO_F      = (OUT_BITS + 1)'(1) << OUT_BITS;
   localparam logic [QBITS:0]      QUARTER    = (QBITS + 1)'(QMAX);

   // quarter-wave magnitude, rounded to the output format
   function automatic logic [OUT_BITS-1:0] sine_entry(input int idx);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] x3;
      logic [63:0] x5;
      logic [63:0] x7;
      logic [63:0] x9;
      logic [63:0] s;
      logic [63:0] mag;
      x   = 64'(idx) << (30 - QBITS);
      x2  = (x * x) >> 30;
      x3  = (x2 * x) >> 30;
      x5  = (x3 * x2) >> 30;
      x7  = (x5 * x2) >> 30;
      x9  = (x7 * x2) >> 30;
      s   = (mwpo_pkg::SIN_C1 * x) >> 30;
      s   = s - ((mwpo_pkg::SIN_C3 * x3) >> 30);
      s   = s + ((mwpo_pkg::SIN_C5 * x5) >> 30);
      s   = s - ((mwpo_pkg::SIN_C7 * x7) >> 30);
      s   = s + ((mwpo_pkg::SIN_C9 * x9) >> 30);
      mag = (s + (64'd1 << (OSH - 1))) >> OSH;
      if (mag > 64'(FULL_SCALE)) begin
         mag = 64'(FULL_SCALE);
      end
      return mag[OUT_BITS-1:0];
   endfunction

   logic [OUT_BITS-1:0]       sine_tab [0:QMAX];

   for (genvar gi = 0; gi <= QMAX; gi++) begin : g_sine_tab
      localparam logic [OUT_BITS-1:0] ENTRY = sine_entry(gi);
      assign sine_tab[gi] = ENTRY;
   end

   logic [EXT_BITS-1:0]       phase_ext;
   logic [SINE_ADDR_BITS-1:0] addr;
   logic [1:0]                quad;
   logic [QBITS:0]            sine_idx;
   logic [OUT_BITS-1:0]       sine_mag;
   logic [OUT_BITS-1:0]       sine_val;
   logic [OUT_BITS-1:0]       t;
   logic [OUT_BITS-1:0]       saw_rise;
   logic [OUT_BITS-1:0]       saw_val;
   logic [OUT_BITS-1:0]       square_val;
   logic [OUT_BITS:0]         u;
   logic [OUT_BITS:0]         tri_abs;
   logic [OUT_BITS-1:0]       tri_val;

   // zero-extended on the right so narrow accumulators still yield wide tops
   assign phase_ext = {phase, {(OUT_BITS + 1){1'b0}}};
   assign addr      = phase_ext[EXT_BITS-1 -: SINE_ADDR_BITS];
   assign t         = phase_ext[EXT_BITS-1 -: OUT_BITS];
   assign u         = phase_ext[EXT_BITS-1 -: OUT_BITS + 1];

   // sine: mirror odd quadrants, negate the second half turn
   assign quad     = addr[SINE_ADDR_BITS-1 -: 2];
   assign sine_idx = quad[0] ? (QUARTER - {1'b0, addr[QBITS-1:0]}) : {1'b0, addr[QBITS-1:0]};
   assign sine_mag = sine_tab[sine_idx];

   always_comb begin
      if (quad[1]) begin
         sine_val = -sine_mag;
      end else if (sine_mag == FULL_SCALE) begin
         sine_val = MAX_POS;
      end else begin
         sine_val = sine_mag;
      end
   end

   assign saw_rise = {~t[OUT_BITS-1], t[OUT_BITS-2:0]};
   assign saw_val  = !cfg.saw_falling ? saw_rise :
                     (t == '0)       ? MAX_POS  : -saw_rise;

   assign square_val = phase[PHASE_BITS-1] ? FULL_SCALE : MAX_POS;

   assign tri_abs = u[OUT_BITS] ? {1'b0, u[OUT_BITS-1:0]} : (TWO_F - {1'b0, u[OUT_BITS-1:0]});
   assign tri_val = (tri_abs == TWO_F) ? MAX_POS : {~tri_abs[OUT_BITS-1], tri_abs[OUT_BITS-2:0]};

   always_comb begin
      case (cfg.wave_mode)
         mwpo_pkg::WAVE_SINE:     sample = $signed(sine_val);
         mwpo_pkg::WAVE_SAW:      sample = $signed(saw_val);
         mwpo_pkg::WAVE_SQUARE:   sample = $signed(square_val);
         mwpo_pkg::WAVE_TRIANGLE: sample = $signed(tri_val);
         default:                 sample = '0;
      endcase
   end

endmodule

/* rtl/multi_waveform_phase_oscillator_unit.sv */
// An accepted request is registered with its phase in s1, then with its sample in s2.
// Throughput: one item per cycle while results are taken; a stalled result does not
// block the next accept while the input register is free.
// Waveform shaping is one pass of table lookup and add/select between the two registers.
// Reset (synchronous, active high) clears the phase accumulator, all config
// registers and both valid flags.
module multi_waveform_phase_oscillator_unit #(
   parameter int PHASE_BITS     = 32,
   parameter int OUT_BITS       = 16,
   parameter int SINE_ADDR_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   mwpo_req_if.sink                            req_ch,
   mwpo_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [mwpo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mwpo_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   mwpo_pkg::cfg_type cfg;

   logic                       req_accept;
   logic                       s1_ready;
   logic                       s2_load;
   logic [PHASE_BITS-1:0]      phase;
   logic signed [OUT_BITS-1:0] sample;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic [PHASE_BITS-1:0]      s1_phase_ff;
   logic                       s1_last_ff;
   logic                       s2_valid_ff;
   logic                       s2_valid_in;
   logic signed [OUT_BITS-1:0] s2_sample_ff;
   logic                       s2_last_ff;

   mwpo_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mwpo_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .advance    (req_accept),
      .phase_step (cfg.phase_step),
      .phase      (phase)
   );

   mwpo_shaper #(
      .PHASE_BITS     (PHASE_BITS),
      .OUT_BITS       (OUT_BITS),
      .SINE_ADDR_BITS (SINE_ADDR_BITS)
   ) u_shaper (
      .phase  (s1_phase_ff),
      .cfg    (cfg),
      .sample (sample)
   );

   assign s1_ready     = !s2_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_ready;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign s2_load      = s1_valid_ff && s1_ready;

   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_ready);
   assign s2_valid_in = s2_load || (s2_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_phase_ff <= phase;
         s1_last_ff  <= req_ch.frame_last;
      end
      if (s2_load) begin
         s2_sample_ff <= sample;
         s2_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_ch.valid       = s2_valid_ff;
   assign rsp_ch.sample_out  = s2_sample_ff;
   assign rsp_ch.sample_last = s2_last_ff;

endmodule

/* rtl/mwpo_checker.sv */
module mwpo_checker #(
   parameter int OUT_BITS = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_frame_last,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [OUT_BITS-1:0] rsp_sample_out,
   input logic                       rsp_sample_last
);

   // results never survive reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an open output always frees the input side
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is taken");

   // with the output flowing, an accepted item reaches the output with its frame_last flag
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && req_ready) ##1 (rsp_ready && !reset)
      |=> rsp_valid && (rsp_sample_last == $past(req_frame_last, 2)))
      else $error("item not delivered with two-cycle latency");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
                                 && $stable(rsp_sample_last))
      else $error("stalled result changed");

endmodule

bind multi_waveform_phase_oscillator_unit mwpo_checker #(
   .OUT_BITS (OUT_BITS)
) u_mwpo_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_frame_last  (req_ch.frame_last),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_sample_out  (rsp_ch.sample_out),
   .rsp_sample_last (rsp_ch.sample_last)
);
